/* rtl/core/tpm_pkg.sv */
package tpm_pkg;

    // operation codes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ACCUM = 2'd1;
    localparam logic [1:0] OP_NORM  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    // 1e6 in Q20.12, and 1.0 in Q16.8
    localparam logic [31:0] TPM_SCALE = 32'd4096000000;
    localparam logic [23:0] LEN_ONE   = 24'd256;

    // divider geometry: rate quotient bits, normalized quotient bits
    localparam int          QUOT_W     = 40;
    localparam logic [5:0]  RATE_STEPS = 6'd40;
    localparam logic [5:0]  NORM_STEPS = 6'd32;

    typedef struct packed {
        logic [1:0]  operation;
        logic [23:0] read_count;
        logic [23:0] eff_length;
    } t_in;

    typedef struct packed {
        logic [31:0] tpm_value;
        logic [1:0]  status;
    } t_out;

    // controller -> datapath commands
    typedef struct packed {
        logic latch;
        logic clr_total;
        logic rate_start;
        logic rate_save;
        logic accum;
        logic mul_lo;
        logic mul_hi;
        logic norm_start;
        logic out_load;
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic div_done;
    } t_sts;

endpackage

/* rtl/core/tpm_div.sv */
module tpm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [63:0]                   i_rem,
    input  logic [tpm_pkg::QUOT_W-1:0]    i_bits,
    input  logic [63:0]                   i_divisor,
    input  logic [5:0]                    i_steps,
    output logic                          o_done,
    output logic [tpm_pkg::QUOT_W-1:0]    o_quot
);

    logic [63:0]                r_rem;
    logic [tpm_pkg::QUOT_W-1:0] r_bits;
    logic [63:0]                r_div;
    logic [tpm_pkg::QUOT_W-1:0] r_quot;
    logic [5:0]                 r_cnt;
    logic                       r_busy;
    logic                       r_done;

    logic [64:0] w_rem2;
    logic [65:0] w_diff;
    logic        w_ge;

    // one restoring step: shift in next dividend bit, trial subtract
    always_comb begin
        w_rem2 = {r_rem, r_bits[tpm_pkg::QUOT_W-1]};
        w_diff = {1'b0, w_rem2} - {2'b00, r_div};
        w_ge   = ~w_diff[65];
    end

    // control: busy flag, step counter, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath: remainder, dividend bits, quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_rem;
            r_bits <= i_bits;
            r_div  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[63:0] : w_rem2[63:0];
            r_bits <= {r_bits[tpm_pkg::QUOT_W-2:0], 1'b0};
            r_quot <= {r_quot[tpm_pkg::QUOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* rtl/core/tpm_dp.sv */
module tpm_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tpm_pkg::t_cmd i_cmd,
    input  tpm_pkg::t_in  i_in_data,
    output tpm_pkg::t_sts o_sts,
    output tpm_pkg::t_out o_out_data
);

    logic [23:0] r_count;
    logic [23:0] r_len;
    logic [39:0] r_rate;
    logic [63:0] r_total;
    logic        r_sat;
    logic [71:0] r_prod;
    logic [31:0] r_tpm;
    logic [1:0]  r_status;

    logic [tpm_pkg::QUOT_W-1:0] w_quot;
    logic                       w_div_start;
    logic [63:0]                w_div_rem;
    logic [tpm_pkg::QUOT_W-1:0] w_div_bits;
    logic [63:0]                w_div_divisor;
    logic [5:0]                 w_div_steps;
    logic [64:0]                w_sum;
    logic [51:0]                w_pp;

    // divider operand select: rate = count*2^24/len, or product/total
    always_comb begin
        w_div_start = i_cmd.rate_start | i_cmd.norm_start;
        if (i_cmd.norm_start) begin
            w_div_rem     = {24'd0, r_prod[71:32]};
            w_div_bits    = {r_prod[31:0], 8'd0};
            w_div_divisor = r_total;
            w_div_steps   = tpm_pkg::NORM_STEPS;
        end else begin
            w_div_rem     = {56'd0, r_count[23:16]};
            w_div_bits    = {r_count[15:0], 24'd0};
            w_div_divisor = {40'd0, r_len};
            w_div_steps   = tpm_pkg::RATE_STEPS;
        end
    end

    tpm_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_rem     (w_div_rem),
        .i_bits    (w_div_bits),
        .i_divisor (w_div_divisor),
        .i_steps   (w_div_steps),
        .o_done    (o_sts.div_done),
        .o_quot    (w_quot)
    );

    // running total add, partial product of one rate half
    always_comb begin
        w_sum = {1'b0, r_total} + {25'd0, r_rate};
        w_pp  = (i_cmd.mul_hi ? {12'd0, r_rate[39:20]} : {12'd0, r_rate[19:0]})
                * {20'd0, tpm_pkg::TPM_SCALE};
    end

    // input capture, short lengths raised to 1.0
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_count <= i_in_data.read_count;
            r_len   <= (i_in_data.eff_length < tpm_pkg::LEN_ONE) ?
                       tpm_pkg::LEN_ONE : i_in_data.eff_length;
        end
        if (i_cmd.rate_save) begin
            r_rate <= w_quot;
        end
        if (i_cmd.mul_lo) begin
            r_prod <= {20'd0, w_pp};
        end else if (i_cmd.mul_hi) begin
            r_prod <= r_prod + {w_pp, 20'd0};
        end
    end

    // total and saturation flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_sat   <= 1'b0;
        end else if (i_cmd.clr_total) begin
            r_total <= '0;
            r_sat   <= 1'b0;
        end else if (i_cmd.accum) begin
            if (w_sum[64]) begin
                r_total <= '1;
                r_sat   <= 1'b1;
            end else begin
                r_total <= w_sum[63:0];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_total == 64'd0) begin
                r_tpm    <= '0;
                r_status <= tpm_pkg::ST_ZERO;
            end else begin
                r_tpm    <= ({24'd0, r_rate} > r_total) ? tpm_pkg::TPM_SCALE
                                                          : w_quot[31:0];
                r_status <= r_sat ? tpm_pkg::ST_SAT : tpm_pkg::ST_OK;
            end
        end
    end

    assign o_out_data.tpm_value = r_tpm;
    assign o_out_data.status    = r_status;

endmodule

/* rtl/core/tpm_ctrl.sv */
module tpm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_op,
    input  logic          i_out_ready,
    input  tpm_pkg::t_sts i_sts,
    output tpm_pkg::t_cmd o_cmd,
    output logic          o_in_ready,
    output logic          o_out_valid
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RATE_GO,
        S_RATE_WAIT,
        S_ACCUM,
        S_MUL_LO,
        S_MUL_HI,
        S_NORM_GO,
        S_NORM_WAIT,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_norm;
    logic   n_norm;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_take;
    logic   w_free;

    assign w_take = (r_state == S_IDLE) && i_in_valid;
    assign w_free = !r_out_valid || i_out_ready;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_norm      = r_norm;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.latch = i_in_valid;
                if (i_in_valid) begin
                    case (i_op)
                        tpm_pkg::OP_CLEAR: o_cmd.clr_total = 1'b1;
                        tpm_pkg::OP_ACCUM: begin
                            n_norm  = 1'b0;
                            n_state = S_RATE_GO;
                        end
                        tpm_pkg::OP_NORM: begin
                            n_norm  = 1'b1;
                            n_state = S_RATE_GO;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_RATE_GO: begin
                o_cmd.rate_start = 1'b1;
                n_state          = S_RATE_WAIT;
            end
            S_RATE_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.rate_save = 1'b1;
                    n_state         = r_norm ? S_MUL_LO : S_ACCUM;
                end
            end
            S_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state     = S_IDLE;
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_NORM_GO;
            end
            S_NORM_GO: begin
                o_cmd.norm_start = 1'b1;
                n_state          = S_NORM_WAIT;
            end
            S_NORM_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // hold the quotient until the output register frees up
                if (w_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_norm      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_norm      <= n_norm;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE) && !w_take ? 1'b1 : (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/core/count_to_tpm_normalizer.sv */
// Clear and unused operations finish in the idle state; accumulate and normalize
// run on the shared radix-2 divider: 40 steps for the rate, and normalize then
// adds the low and high multiply steps and 32 steps for the scaled quotient.
// One transaction is in work at a time; the result register lets the next
// transaction enter while a result still waits to be taken.
// Synchronous active-low reset clears the running total, the flag and all control.
module count_to_tpm_normalizer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tpm_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tpm_pkg::t_out o_out_data
);

    tpm_pkg::t_cmd w_cmd;
    tpm_pkg::t_sts w_sts;

    tpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_in_data.operation),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    tpm_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_data  (i_in_data),
        .o_sts      (w_sts),
        .o_out_data (o_out_data)
    );

`ifndef NO_ASSERTIONS
    // divider never finishes while the block is taking new transactions
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.div_done |-> !o_in_ready)
        else $error("divider done while idle");

    // a new result appears only after work, never straight from idle
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.out_load))
        else $error("result without load");

    // zero-total status always carries a zero value
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == tpm_pkg::ST_ZERO))
            |-> (o_out_data.tpm_value == 32'd0))
        else $error("zero total with nonzero value");
`endif

endmodule
